// File: src/bond_spring_force_macros.svh
// Assertion macros used by the checker file.
`ifndef BOND_SPRING_FORCE_MACROS_SVH
`define BOND_SPRING_FORCE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BSF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bond_spring_force assertion failed");

// Next-cycle implication, disabled in reset.
`define BSF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bond_spring_force assertion failed");

`endif

// File: src/bsf_pkg.sv
// Types and constants of the bond spring force pipeline.
`default_nettype none
package bsf_pkg;

   localparam int SQRT_STEPS = 34;        // root bits of the squared length
   localparam int QUO_BITS   = 32;        // quotient bits of the unit vector
   localparam int AXES       = 3;

   localparam logic [49:0] POS_LIM = 50'h0_7FFF_FFFF_FFFF;
   localparam logic [49:0] NEG_LIM = 50'h0_8000_0000_0000;

   typedef struct packed {
      logic               bond_enabled;
      logic [15:0]        sphere_a_index;
      logic [15:0]        sphere_b_index;
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic signed [31:0] a_pos_z;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic signed [31:0] b_pos_z;
      logic [31:0]        rest_length;
      logic [31:0]        stiffness;
      logic               last_bond;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_a_index;
      logic [15:0]        out_b_index;
      logic signed [47:0] normal_force;
      logic signed [47:0] force_x;
      logic signed [47:0] force_y;
      logic signed [47:0] force_z;
      logic               last_out;
   } rsp_type;

   // data that rides along the pipeline with each bond
   typedef struct packed {
      logic                    en;
      logic [15:0]             a_idx;
      logic [15:0]             b_idx;
      logic                    last;
      logic [31:0]             rest;
      logic [31:0]             k;
      logic [AXES-1:0]         dneg;
      logic [AXES-1:0][32:0]   dmag;
      logic [32:0]             len;
      logic                    zero;
      logic                    fneg;
      logic [47:0]             fmag;
      logic [47:0]             fn;
   } bond_type;

   typedef struct packed {
      logic [67:0] rad;
      logic [36:0] rem;
      logic [33:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [AXES-1:0][63:0]         num;
      logic [AXES-1:0][32:0]         rem;
      logic [AXES-1:0][QUO_BITS-1:0] quo;
   } div_type;

   // saturate a magnitude and give it a sign
   function automatic logic [47:0] sign_sat(input logic [49:0] mag, input logic neg);
      logic [49:0] m;
      logic [49:0] r;
      if (neg) begin
         m = (mag > NEG_LIM) ? NEG_LIM : mag;
         r = 50'd0 - m;
      end else begin
         m = (mag > POS_LIM) ? POS_LIM : mag;
         r = m;
      end
      return r[47:0];
   endfunction

endpackage
`default_nettype wire

// File: src/bsf_if.sv
// Channel interfaces: bond request words and force response words.
`default_nettype none
interface bsf_req_if import bsf_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bsf_rsp_if import bsf_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/bsf_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per stage.
`default_nettype none
module bsf_sqrt_cell import bsf_pkg::*; #(
   parameter int PAIR = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire logic     valid_in,
   input  wire bond_type carry_in,
   input  wire sqrt_type st_in,
   output logic          valid_out,
   output bond_type      carry_out,
   output sqrt_type      st_out
);
   logic     valid_ff;
   bond_type carry_ff;
   sqrt_type st_ff, st_in_c;
   logic [36:0] rem_s, trial;

   // shift in the next radicand pair and try the subtract
   always_comb begin
      rem_s   = {st_in.rem[34:0], st_in.rad[2*PAIR+1 -: 2]};
      trial   = {1'b0, st_in.root, 2'b01};
      st_in_c = st_in;
      if (rem_s >= trial) begin
         st_in_c.rem  = rem_s - trial;
         st_in_c.root = {st_in.root[32:0], 1'b1};
      end else begin
         st_in_c.rem  = rem_s;
         st_in_c.root = {st_in.root[32:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff <= carry_in;
         st_ff    <= st_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign carry_out = carry_ff;
   assign st_out    = st_ff;
endmodule
`default_nettype wire

// File: src/bsf_div_cell.sv
// One cell of the divider chain: one quotient bit for each of the three axes.
`default_nettype none
module bsf_div_cell import bsf_pkg::*; #(
   parameter int QBIT = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire logic     valid_in,
   input  wire bond_type carry_in,
   input  wire div_type  st_in,
   output logic          valid_out,
   output bond_type      carry_out,
   output div_type       st_out
);
   logic     valid_ff;
   bond_type carry_ff;
   div_type  st_ff, st_in_c;
   logic [33:0] rem_s;

   // restoring step per lane against the bond length
   always_comb begin
      st_in_c = st_in;
      rem_s   = '0;
      for (int j = 0; j < AXES; j++) begin
         rem_s = {st_in.rem[j], st_in.num[j][QBIT]};
         if (rem_s >= {1'b0, carry_in.len}) begin
            rem_s = rem_s - {1'b0, carry_in.len};
            st_in_c.quo[j][QBIT] = 1'b1;
         end else begin
            st_in_c.quo[j][QBIT] = 1'b0;
         end
         st_in_c.rem[j] = rem_s[32:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff <= carry_in;
         st_ff    <= st_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign carry_out = carry_ff;
   assign st_out    = st_ff;
endmodule
`default_nettype wire

// File: src/bond_spring_force.sv
// Top level of the bond spring force pipeline.
//
// One bond word enters on req_ch, one force word leaves on rsp_ch, in order.
// A word moves when valid and ready are both high at a rising clock edge.
// The pipeline takes one bond per cycle while the output does not stall.
// A bond passes 75 register stages: 3 form the separation, squares and
// their sum, 34 cells of the square root chain settle one root bit each,
// 3 form the normal force, 32 divider cells give one unit-vector bit each
// for all three axes, and 3 scale, saturate and register the result.
// The response word is registered in out_ff, the last of these stages.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and req_ch.ready drops in the same cycle; it rises as soon as the word
// is taken, so no cycle is lost once the receiver is ready again.
// Synchronous reset empties the pipeline; words in flight are dropped.
// The block keeps no state between bonds.
`default_nettype none
module bond_spring_force import bsf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   bsf_req_if.sink   req_ch,
   bsf_rsp_if.source rsp_ch
);
   localparam int NS = SQRT_STEPS;
   localparam int ND = QUO_BITS;

   logic adv;

   // front stages
   logic     v1_ff, v2_ff, v3_ff;
   bond_type c1_ff, c2_ff, c3_ff;
   logic [AXES-1:0][65:0] sq_ff;
   logic [67:0] sum_ff;

   // square root chain
   logic     sv [0:NS];
   bond_type sc [0:NS];
   sqrt_type ss [0:NS];

   // normal force stages
   logic     f1_v_ff, f2_v_ff, f3_v_ff;
   bond_type f1_c_ff, f2_c_ff, f3_c_ff;
   logic [33:0] smag_ff;
   logic [63:0] prod_ff;
   logic        s32_ff;

   // divider chain
   logic     dv [0:ND];
   bond_type dc [0:ND];
   div_type  ds [0:ND];

   // back stages
   logic     p1_v_ff, p2_v_ff, out_v_ff;
   bond_type p1_c_ff, p2_c_ff;
   logic [AXES-1:0][55:0] hi_ff;
   logic [AXES-1:0][56:0] lo_ff;
   logic [AXES-1:0][50:0] mag_ff;
   rsp_type out_ff;

   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // valid bits of the fixed stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         f1_v_ff <= 1'b0; f2_v_ff <= 1'b0; f3_v_ff <= 1'b0;
         p1_v_ff <= 1'b0; p2_v_ff <= 1'b0; out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid; v2_ff <= v1_ff; v3_ff <= v2_ff;
         f1_v_ff <= sv[NS]; f2_v_ff <= f1_v_ff; f3_v_ff <= f2_v_ff;
         p1_v_ff <= dv[ND]; p2_v_ff <= p1_v_ff; out_v_ff <= p2_v_ff;
      end
   end

   // separation vector, squares, squared length
   always_ff @(posedge clock) begin
      logic signed [32:0] d [AXES];
      bond_type           cin;
      if (adv) begin
         d[0] = 33'(req_ch.data.a_pos_x) - 33'(req_ch.data.b_pos_x);
         d[1] = 33'(req_ch.data.a_pos_y) - 33'(req_ch.data.b_pos_y);
         d[2] = 33'(req_ch.data.a_pos_z) - 33'(req_ch.data.b_pos_z);
         cin       = '0;
         cin.en    = req_ch.data.bond_enabled;
         cin.a_idx = req_ch.data.sphere_a_index;
         cin.b_idx = req_ch.data.sphere_b_index;
         cin.last  = req_ch.data.last_bond;
         cin.rest  = req_ch.data.rest_length;
         cin.k     = req_ch.data.stiffness;
         for (int j = 0; j < AXES; j++) begin
            cin.dneg[j] = d[j][32];
            cin.dmag[j] = d[j][32] ? 33'd0 - 33'(d[j]) : 33'(d[j]);
         end
         c1_ff <= cin;
         c2_ff <= c1_ff;
         for (int j = 0; j < AXES; j++) begin
            sq_ff[j] <= 66'(c1_ff.dmag[j]) * 66'(c1_ff.dmag[j]);
         end
         c3_ff  <= c2_ff;
         sum_ff <= 68'(sq_ff[0]) + 68'(sq_ff[1]) + 68'(sq_ff[2]);
      end
   end

   // square root chain, most significant pair first
   assign sv[0]      = v3_ff;
   assign sc[0]      = c3_ff;
   assign ss[0].rad  = sum_ff;
   assign ss[0].rem  = '0;
   assign ss[0].root = '0;

   for (genvar n = 0; n < NS; n++) begin : g_sqrt
      bsf_sqrt_cell #(.PAIR(NS - 1 - n)) u_cell (
         .clock, .reset, .adv,
         .valid_in (sv[n]),   .carry_in (sc[n]),   .st_in (ss[n]),
         .valid_out(sv[n+1]), .carry_out(sc[n+1]), .st_out(ss[n+1])
      );
   end

   // stretch, product with stiffness, rounding and saturation
   always_ff @(posedge clock) begin
      logic [34:0] stretch;
      logic [49:0] mag;
      logic [47:0] fn;
      bond_type    c1;
      bond_type    c3;
      if (adv) begin
         stretch = {2'b00, ss[NS].root[32:0]} - {3'b000, sc[NS].rest};
         c1      = sc[NS];
         c1.len  = ss[NS].root[32:0];
         c1.zero = (ss[NS].root == '0);
         c1.fneg = stretch[34];
         f1_c_ff <= c1;
         smag_ff <= stretch[34] ? 34'(35'd0 - stretch) : stretch[33:0];

         f2_c_ff <= f1_c_ff;
         prod_ff <= 64'(f1_c_ff.k) * 64'(smag_ff[31:0]);
         s32_ff  <= smag_ff[32] | smag_ff[33];

         mag = 50'((65'(prod_ff) + 65'h8000) >> 16)
             + (s32_ff ? {2'b00, f2_c_ff.k, 16'h0000} : 50'd0);
         fn = sign_sat(mag, f2_c_ff.fneg);
         c3      = f2_c_ff;
         c3.fn   = fn;
         c3.fmag = f2_c_ff.fneg ? 48'd0 - fn : fn;
         f3_c_ff <= c3;
      end
   end

   // divider chain for the unit vector
   assign dv[0] = f3_v_ff;
   assign dc[0] = f3_c_ff;
   always_comb begin
      logic [63:0] num;
      ds[0] = '0;
      for (int j = 0; j < AXES; j++) begin
         num = {1'b0, f3_c_ff.dmag[j], 30'd0} + 64'(f3_c_ff.len[32:1]);
         ds[0].num[j] = num;
         ds[0].rem[j] = {1'b0, num[63:32]};
      end
   end

   for (genvar n = 0; n < ND; n++) begin : g_div
      bsf_div_cell #(.QBIT(ND - 1 - n)) u_cell (
         .clock, .reset, .adv,
         .valid_in (dv[n]),   .carry_in (dc[n]),   .st_in (ds[n]),
         .valid_out(dv[n+1]), .carry_out(dc[n+1]), .st_out(ds[n+1])
      );
   end

   // force scaling in two partial products, then sign and saturation
   always_ff @(posedge clock) begin
      logic [47:0] f [AXES];
      logic        gate;
      if (adv) begin
         p1_c_ff <= dc[ND];
         for (int j = 0; j < AXES; j++) begin
            hi_ff[j] <= 56'(dc[ND].fmag[47:24]) * 56'(ds[ND].quo[j]);
            lo_ff[j] <= 57'(dc[ND].fmag[23:0]) * 57'(ds[ND].quo[j]) + 57'(1) * (57'd1 << 29);
         end

         p2_c_ff <= p1_c_ff;
         for (int j = 0; j < AXES; j++) begin
            mag_ff[j] <= 51'(hi_ff[j] >> 6)
                       + 51'((58'({hi_ff[j][5:0], 24'd0}) + 58'(lo_ff[j])) >> 30);
         end

         gate = p2_c_ff.en && !p2_c_ff.zero;
         for (int j = 0; j < AXES; j++) begin
            if (mag_ff[j] == '0 || !gate) begin
               f[j] = '0;
            end else begin
               f[j] = sign_sat((mag_ff[j] > 51'(NEG_LIM)) ? NEG_LIM : mag_ff[j][49:0],
                               p2_c_ff.fneg == p2_c_ff.dneg[j]);
            end
         end
         out_ff.out_a_index  <= p2_c_ff.a_idx;
         out_ff.out_b_index  <= p2_c_ff.b_idx;
         out_ff.last_out     <= p2_c_ff.last;
         out_ff.normal_force <= gate ? p2_c_ff.fn : 48'd0;
         out_ff.force_x      <= f[0];
         out_ff.force_y      <= f[1];
         out_ff.force_z      <= f[2];
      end
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.data  = out_ff;
endmodule
`default_nettype wire

// File: src/bsf_checker.sv
// Port-level checks of the bond spring force block, bound to its top level.
`default_nettype none
`include "bond_spring_force_macros.svh"
module bsf_checker import bsf_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   logic any_force;
   assign any_force = (rsp_data.force_x != '0) || (rsp_data.force_y != '0)
                    || (rsp_data.force_z != '0);

   // a waiting response word holds
   `BSF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `BSF_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))
   // intake stops only behind a stalled response
   `BSF_ASSERT_IMPL(a_ready_stall, !req_ready, rsp_valid && !rsp_ready)
   // a force on A needs a nonzero normal force
   `BSF_ASSERT_IMPL(a_force_needs_fn, rsp_valid && any_force, rsp_data.normal_force != '0)
endmodule

bind bond_spring_force bsf_checker u_bsf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
`default_nettype wire
